// ===== sv/rhfe_pkg.sv =====
package rhfe_pkg;

	// Frequency bounds of the two mapped bands, in MHz.
	localparam logic [15:0] FREQ_CH14    = 16'd2484;
	localparam logic [15:0] FREQ_24_LO   = 16'd2412;
	localparam logic [15:0] FREQ_24_HI   = 16'd2472;
	localparam logic [15:0] FREQ_24_BASE = 16'd2407;
	localparam logic [15:0] FREQ_5_LO    = 16'd5160;
	localparam logic [15:0] FREQ_5_HI    = 16'd5885;
	localparam logic [15:0] FREQ_5_BASE  = 16'd5000;
	localparam logic [7:0]  CHAN_14      = 8'd14;

	// Division by five of a value below 1024: multiply by 205 and drop ten bits.
	localparam logic [7:0]  DIV5_MUL     = 8'd205;

	// Byte offsets inside the radiotap header.
	localparam int unsigned PRESENT_FIRST_BYTE = 4;

	// Bits of the first present word that the block follows.
	localparam int unsigned BIT_TSFT    = 0;
	localparam int unsigned BIT_FLAGS   = 1;
	localparam int unsigned BIT_RATE    = 2;
	localparam int unsigned BIT_CHANNEL = 3;
	localparam int unsigned BIT_FHSS    = 4;
	localparam int unsigned BIT_SIGNAL  = 5;

	// Bit of the flags byte that marks a trailing FCS, and the chain bit of a word's last byte.
	localparam int unsigned FLAG_FCS_BIT = 4;
	localparam int unsigned EXT_BIT      = 7;

	typedef logic [5:0] present_bits_t;

	function automatic logic [7:0] mhz_to_channel(input logic [15:0] f);
		logic [15:0] diff;
		logic [17:0] prod;
		logic        banded;
		logic [7:0]  ch;
		diff   = '0;
		banded = 1'b0;
		ch     = '0;
		if (f >= FREQ_24_LO && f <= FREQ_24_HI) begin
			diff   = f - FREQ_24_BASE;
			banded = 1'b1;
		end else if (f >= FREQ_5_LO && f <= FREQ_5_HI) begin
			diff   = f - FREQ_5_BASE;
			banded = 1'b1;
		end
		prod = 18'(diff[9:0] * DIV5_MUL);
		if (f == FREQ_CH14) begin
			ch = CHAN_14;
		end else if (banded) begin
			ch = prod[17:10];
		end
		return ch;
	endfunction

endpackage

// ===== sv/radiotap_header_field_extractor.sv =====
// Radiotap header field extractor.
// A captured frame enters one byte per request on the byte channel
// (byte_valid/byte_ready with data_byte, frame_start and frame_end); the
// first byte of a frame carries frame_start and the last carries frame_end.
// For each frame the block gives at most one request on the result channel
// (result_valid/result_ready): channel number from the channel field's MHz
// value, antenna signal in dBm, the FCS flag, the number of present words and
// a truncated mark when the frame ended before the needed fields came by.
// An accepted byte sits in the input register until it is evaluated, which
// waits while an earlier result is not yet taken; a result the byte causes
// is then written to the result register and shows on the result ports.
// Throughput: one byte per cycle while no result waits untaken, set by the single
// evaluation pass per byte between the input register and the result register.
// Reset clears the pipeline, drops any result not yet taken, and leaves the
// block idle: bytes are ignored until one carries frame_start.
// When the receiver stalls with a result waiting, the input register still
// accepts one byte; further bytes wait until the result is taken.
module radiotap_header_field_extractor
	import rhfe_pkg::*;
#(
	parameter int unsigned POSITION_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              byte_valid,
	output logic              byte_ready,
	input  logic [7:0]        data_byte,
	input  logic              frame_start,
	input  logic              frame_end,
	output logic              result_valid,
	input  logic              result_ready,
	output logic [7:0]        channel_number,
	output logic              channel_valid,
	output logic signed [7:0] signal_dbm,
	output logic              signal_valid,
	output logic              fcs_present,
	output logic [7:0]        present_word_count,
	output logic              truncated
);

	localparam int unsigned PB = POSITION_BITS;
	// Field placement adds at most 26 bytes beyond the chain end, within five extra bits.
	localparam int unsigned OW = POSITION_BITS + 5;
	localparam logic [PB-1:0] POS_MAX = '1;

	typedef logic [PB-1:0] pos_t;
	typedef logic [OW-1:0] off_t;

	function automatic pos_t clamp_pos(input off_t v);
		return (v > off_t'(POS_MAX)) ? POS_MAX : v[PB-1:0];
	endfunction

	// Input register.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       start_s1;
	logic       end_s1;

	// Frame state.
	pos_t          pos_q;
	present_bits_t fpb_q;
	logic          chain_q;
	logic [7:0]    words_q;
	pos_t          fields_start_q;
	pos_t          flags_pos_q;
	pos_t          freq_pos_q;
	pos_t          signal_pos_q;
	logic [7:0]    freq_low_q;
	logic [8:0]    chan_hold_q;
	logic          fcs_q;
	logic          done_q;

	// Result register.
	logic       res_valid_q;
	logic [7:0] chan_num_q;
	logic       chan_ok_q;
	logic [7:0] sig_q;
	logic       sig_ok_q;
	logic       fcs_out_q;
	logic [7:0] words_out_q;
	logic       trunc_q;

	logic advance;
	logic process;

	assign advance    = !res_valid_q || result_ready;
	assign byte_ready = !valid_s1 || advance;
	assign process    = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ready) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && byte_ready) begin
			byte_s1  <= data_byte;
			start_s1 <= frame_start;
			end_s1   <= frame_end;
		end
	end

	// State as the byte sees it: a frame start restarts everything.
	pos_t          cur_pos;
	present_bits_t cur_fpb;
	logic          cur_chain;
	logic [7:0]    cur_words;
	pos_t          cur_fields_start;
	pos_t          cur_flags_pos;
	pos_t          cur_freq_pos;
	pos_t          cur_signal_pos;
	logic [7:0]    cur_freq_low;
	logic [8:0]    cur_chan_hold;
	logic          cur_fcs;
	logic          cur_done;

	always_comb begin
		if (start_s1) begin
			cur_pos          = '0;
			cur_fpb          = '0;
			cur_chain        = 1'b1;
			cur_words        = '0;
			cur_fields_start = '0;
			cur_flags_pos    = '0;
			cur_freq_pos     = '0;
			cur_signal_pos   = '0;
			cur_freq_low     = '0;
			cur_chan_hold    = '0;
			cur_fcs          = 1'b0;
			cur_done         = 1'b0;
		end else begin
			cur_pos          = pos_q;
			cur_fpb          = fpb_q;
			cur_chain        = chain_q;
			cur_words        = words_q;
			cur_fields_start = fields_start_q;
			cur_flags_pos    = flags_pos_q;
			cur_freq_pos     = freq_pos_q;
			cur_signal_pos   = signal_pos_q;
			cur_freq_low     = freq_low_q;
			cur_chan_hold    = chan_hold_q;
			cur_fcs          = fcs_q;
			cur_done         = done_q;
		end
	end

	// Field placement after the present chain, with the natural alignment of
	// TSFT (8), flags (1), rate (1), channel (2), FHSS (2) and signal (1).
	off_t off_start, off_tsft, off_rate, off_chan, off_after_chan, off_fhss;
	off_t tsft_up, chan_up, fhss_up;
	pos_t place_flags, place_freq, place_signal;

	always_comb begin
		off_start = off_t'(cur_pos) + off_t'(1);
		tsft_up   = off_start + off_t'(7);
		off_tsft  = cur_fpb[BIT_TSFT] ? ({tsft_up[OW-1:3], 3'b000} + off_t'(8)) : off_start;
		off_rate  = off_tsft + off_t'(cur_fpb[BIT_FLAGS]) + off_t'(cur_fpb[BIT_RATE]);
		chan_up   = off_rate + off_t'(1);
		off_chan  = cur_fpb[BIT_CHANNEL] ? {chan_up[OW-1:1], 1'b0} : off_rate;
		off_after_chan = cur_fpb[BIT_CHANNEL] ? (off_chan + off_t'(4)) : off_chan;
		fhss_up   = off_after_chan + off_t'(1);
		off_fhss  = cur_fpb[BIT_FHSS] ? ({fhss_up[OW-1:1], 1'b0} + off_t'(2)) : off_after_chan;
		place_flags  = clamp_pos(off_tsft);
		place_freq   = clamp_pos(off_chan);
		place_signal = clamp_pos(off_fhss);
	end

	// Per-byte evaluation.
	present_bits_t nxt_fpb;
	logic          nxt_chain;
	logic [7:0]    nxt_words;
	pos_t          nxt_fields_start;
	pos_t          nxt_flags_pos;
	pos_t          nxt_freq_pos;
	pos_t          nxt_signal_pos;
	logic [7:0]    nxt_freq_low;
	logic [8:0]    nxt_chan_hold;
	logic          nxt_fcs;
	pos_t          nxt_pos;
	logic          emit_sig;
	logic          emit_last;
	logic          emit_trunc;
	logic          emit_any;
	logic          in_range;
	logic          word_end;
	logic [PB:0]   p_ext;
	logic [PB:0]   last_pos;

	always_comb begin
		nxt_fpb          = cur_fpb;
		nxt_chain        = cur_chain;
		nxt_words        = cur_words;
		nxt_fields_start = cur_fields_start;
		nxt_flags_pos    = cur_flags_pos;
		nxt_freq_pos     = cur_freq_pos;
		nxt_signal_pos   = cur_signal_pos;
		nxt_freq_low     = cur_freq_low;
		nxt_chan_hold    = cur_chan_hold;
		nxt_fcs          = cur_fcs;
		nxt_pos          = cur_pos;
		emit_sig         = 1'b0;
		emit_last        = 1'b0;
		emit_trunc       = 1'b0;
		p_ext            = {1'b0, cur_pos};
		in_range         = (cur_pos != POS_MAX);
		word_end         = (cur_pos >= pos_t'(PRESENT_FIRST_BYTE)) && (cur_pos[1:0] == 2'b11);
		last_pos         = '1;

		if (!cur_done && in_range) begin
			if (cur_pos == pos_t'(PRESENT_FIRST_BYTE)) begin
				nxt_fpb = byte_s1[5:0];
			end
			if (cur_chain) begin
				if (word_end) begin
					if (cur_words != 8'hFF) begin
						nxt_words = cur_words + 8'd1;
					end
					if (!byte_s1[EXT_BIT]) begin
						nxt_chain        = 1'b0;
						nxt_fields_start = clamp_pos(off_start);
						nxt_flags_pos    = place_flags;
						nxt_freq_pos     = place_freq;
						nxt_signal_pos   = place_signal;
					end
				end
			end else begin
				if (cur_fpb[BIT_FLAGS] && cur_pos == cur_flags_pos) begin
					nxt_fcs = byte_s1[FLAG_FCS_BIT];
				end
				if (cur_fpb[BIT_CHANNEL]) begin
					if (cur_pos == cur_freq_pos) begin
						nxt_freq_low = byte_s1;
					end else if (p_ext == ({1'b0, cur_freq_pos} + 1'b1)) begin
						nxt_chan_hold = {1'b1, mhz_to_channel({byte_s1, cur_freq_low})};
					end
				end
				if (cur_fpb[BIT_SIGNAL] && cur_pos == cur_signal_pos) begin
					emit_sig = 1'b1;
				end
			end

			// Without a signal field, the result goes out on the last needed byte.
			priority if (nxt_fpb[BIT_CHANNEL]) begin
				last_pos = {1'b0, nxt_freq_pos} + 1'b1;
			end else if (nxt_fpb[BIT_FLAGS]) begin
				last_pos = {1'b0, nxt_flags_pos};
			end else begin
				last_pos = {1'b0, nxt_fields_start} - 1'b1;
			end
			if (!emit_sig && !nxt_chain && !nxt_fpb[BIT_SIGNAL] && p_ext == last_pos) begin
				emit_last = 1'b1;
			end
			nxt_pos = cur_pos + pos_t'(1);
		end

		if (!cur_done && !emit_sig && !emit_last && end_s1) begin
			emit_trunc = 1'b1;
		end
		emit_any = emit_sig || emit_last || emit_trunc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q          <= '0;
			fpb_q          <= '0;
			chain_q        <= 1'b0;
			words_q        <= '0;
			fields_start_q <= '0;
			flags_pos_q    <= '0;
			freq_pos_q     <= '0;
			signal_pos_q   <= '0;
			freq_low_q     <= '0;
			chan_hold_q    <= '0;
			fcs_q          <= 1'b0;
			done_q         <= 1'b1;
		end else if (process) begin
			pos_q          <= nxt_pos;
			fpb_q          <= nxt_fpb;
			chain_q        <= nxt_chain;
			words_q        <= nxt_words;
			fields_start_q <= nxt_fields_start;
			flags_pos_q    <= nxt_flags_pos;
			freq_pos_q     <= nxt_freq_pos;
			signal_pos_q   <= nxt_signal_pos;
			freq_low_q     <= nxt_freq_low;
			chan_hold_q    <= nxt_chan_hold;
			fcs_q          <= nxt_fcs;
			done_q         <= cur_done || emit_any;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (process && emit_any) begin
			res_valid_q <= 1'b1;
		end else if (result_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (process && emit_any) begin
			chan_num_q  <= nxt_chan_hold[8] ? nxt_chan_hold[7:0] : 8'd0;
			chan_ok_q   <= nxt_chan_hold[8];
			sig_q       <= emit_sig ? byte_s1 : 8'd0;
			sig_ok_q    <= emit_sig;
			fcs_out_q   <= nxt_fcs;
			words_out_q <= nxt_words;
			trunc_q     <= emit_trunc;
		end
	end

	assign result_valid       = res_valid_q;
	assign channel_number     = chan_num_q;
	assign channel_valid      = chan_ok_q;
	assign signal_dbm         = signed'(sig_q);
	assign signal_valid       = sig_ok_q;
	assign fcs_present        = fcs_out_q;
	assign present_word_count = words_out_q;
	assign truncated          = trunc_q;

endmodule

// ===== sv/rhfe_checker.sv =====
module rhfe_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              result_valid,
	input logic              result_ready,
	input logic [7:0]        channel_number,
	input logic              channel_valid,
	input logic signed [7:0] signal_dbm,
	input logic              signal_valid,
	input logic              fcs_present,
	input logic [7:0]        present_word_count,
	input logic              truncated
);

	// A stalled result keeps its request and its contents.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(channel_number)
			&& $stable(channel_valid) && $stable(signal_dbm) && $stable(signal_valid)
			&& $stable(fcs_present) && $stable(present_word_count) && $stable(truncated))
		else $error("stalled result changed");

	// Fields that were not read come out as zero.
	a_chan_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !channel_valid |-> channel_number == 8'd0)
		else $error("channel number set without channel field");

	a_sig_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !signal_valid |-> signal_dbm == 8'sd0)
		else $error("signal set without signal field");

	// A complete result needs the whole present chain, so at least one word.
	a_complete_chain: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !truncated |-> present_word_count != 8'd0)
		else $error("complete result with empty present chain");

	a_sig_complete: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && signal_valid |-> !truncated)
		else $error("signal read but result marked truncated");

endmodule

bind radiotap_header_field_extractor rhfe_checker u_rhfe_checker (.*);
